// ===== src/bged_pkg.sv =====
// ----------------------------------------------------------------------------
// bged_pkg
// types and constants shared by the button gesture event detector
// ----------------------------------------------------------------------------
package bged_pkg;

  // event codes
  localparam logic [2:0] EV_RELEASE = 3'd0;
  localparam logic [2:0] EV_PRESS   = 3'd1;
  localparam logic [2:0] EV_CLICK   = 3'd2;
  localparam logic [2:0] EV_LONG    = 3'd3;
  localparam logic [2:0] EV_REPEAT  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_ACTIVE_HIGH  = 3'd0;
  localparam logic [2:0] CFG_DEBOUNCE     = 3'd1;
  localparam logic [2:0] CFG_MAX_CLICKS   = 3'd2;
  localparam logic [2:0] CFG_CLICK_GAP    = 3'd3;
  localparam logic [2:0] CFG_LONG_PRESS   = 3'd4;
  localparam logic [2:0] CFG_REPEAT       = 3'd5;
  localparam logic [2:0] CFG_CLEAR_CLICK  = 3'd6;

  // configuration reset values
  localparam logic        DEF_ACTIVE_HIGH = 1'b0;
  localparam logic [7:0]  DEF_DEBOUNCE    = 8'd10;
  localparam logic [3:0]  DEF_MAX_CLICKS  = 4'd1;
  localparam logic [15:0] DEF_CLICK_GAP   = 16'd300;
  localparam logic [15:0] DEF_LONG_PRESS  = 16'd500;
  localparam logic [15:0] DEF_REPEAT      = 16'd100;
  localparam logic        DEF_CLEAR_CLICK = 1'b1;

  // raw sample markers
  localparam logic [1:0] SAMPLE_NONE = 2'd0;

  // output event queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic       req_type;
    logic [1:0] key_index;
    logic       pin_level;
  } bged_in_t;

  typedef struct packed {
    logic [1:0] event_key;
    logic [2:0] event_code;
    logic [3:0] click_count;
    logic       last_event;
  } bged_out_t;

endpackage

// ===== src/button_gesture_event_detector_top.sv =====
// ----------------------------------------------------------------------------
// button_gesture_event_detector_top
// per-key debounce, press/release, click, multi-click, long press and repeat
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | in        | in_valid / in_stall   | bged_in_t  (sample or reset)
//   out     | out       | out_valid / out_stall | bged_out_t (one event)
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// an input item is processed in the cycle it is transferred: the key state is
// read, updated and written back, and its zero to two events enter a four-entry
// event queue that drives the out channel directly
// one input item per cycle while in_stall is low; each event takes one out
// transfer, so an item with two events needs two out transfers, and in_stall
// rises while fewer than two queue entries are free
// rst is synchronous: key state, queue pointers and settings return to defaults
// cfg_ready is always high; settings apply to the next transferred item
//
module button_gesture_event_detector_top
  import bged_pkg::*;
#(
  parameter int NUM_KEYS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  bged_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output bged_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // settings
  logic        active_high;
  logic [7:0]  debounce_ticks;
  logic [3:0]  max_clicks;
  logic [15:0] click_gap_ticks;
  logic [15:0] long_press_ticks;
  logic [15:0] repeat_ticks;
  logic        clear_click_after_long;

  // per-key state
  logic [1:0]  previous_sample [NUM_KEYS];
  logic        stable_flag     [NUM_KEYS];
  logic [7:0]  debounce_count  [NUM_KEYS];
  logic [15:0] hold_count      [NUM_KEYS];
  logic        long_started    [NUM_KEYS];
  logic        ignore_click    [NUM_KEYS];
  logic [3:0]  clicks_so_far   [NUM_KEYS];
  logic [15:0] gap_count       [NUM_KEYS];

  // event queue
  bged_out_t          queue [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  logic              in_fire;
  logic              out_fire;
  logic              key_ok;
  logic [KEY_W-1:0]  key_sel;

  // next values of the addressed key
  logic [1:0]  sample_next;
  logic        stable_next;
  logic [7:0]  debounce_next;
  logic [15:0] hold_next;
  logic        long_next;
  logic        ignore_next;
  logic [3:0]  clicks_next;
  logic [15:0] gap_next;

  // candidate events, in report order
  logic [2:0]  cand_valid;
  bged_out_t   cand [3];
  bged_out_t   ev0;
  bged_out_t   ev1;
  logic [1:0]  push_n;

  // settings after their special cases
  logic [15:0] lpt;
  logic [15:0] rep;
  logic [3:0]  maxc;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign key_ok   = 32'(in_data.key_index) < NUM_KEYS;
  assign key_sel  = KEY_W'(in_data.key_index);

  assign cfg_ready = 1'b1;
  assign in_stall  = count > QCNT_W'(QDEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = queue[rd_ptr];

  assign lpt  = (long_press_ticks != '0) ? long_press_ticks : 16'd1;
  assign rep  = (repeat_ticks < lpt) ? repeat_ticks : 16'd0;
  assign maxc = (max_clicks != '0) ? max_clicks : 4'd1;

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_high            <= DEF_ACTIVE_HIGH;
      debounce_ticks         <= DEF_DEBOUNCE;
      max_clicks             <= DEF_MAX_CLICKS;
      click_gap_ticks        <= DEF_CLICK_GAP;
      long_press_ticks       <= DEF_LONG_PRESS;
      repeat_ticks           <= DEF_REPEAT;
      clear_click_after_long <= DEF_CLEAR_CLICK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_HIGH: active_high            <= cfg_data[0];
        CFG_DEBOUNCE:    debounce_ticks         <= cfg_data[7:0];
        CFG_MAX_CLICKS:  max_clicks             <= cfg_data[3:0];
        CFG_CLICK_GAP:   click_gap_ticks        <= cfg_data;
        CFG_LONG_PRESS:  long_press_ticks       <= cfg_data;
        CFG_REPEAT:      repeat_ticks           <= cfg_data;
        CFG_CLEAR_CLICK: clear_click_after_long <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // gesture logic for the addressed key
  always_comb begin
    logic        pressed;
    logic [1:0]  sample;
    logic [7:0]  db_inc;
    logic [15:0] hold_inc;
    logic [15:0] gap_mid;
    logic [3:0]  clicks_mid;
    logic        quick;

    pressed    = in_data.pin_level == active_high;
    sample     = {in_data.pin_level, ~in_data.pin_level};
    db_inc     = debounce_count[key_sel] + 8'd1;
    hold_inc   = hold_count[key_sel] + 16'd1;
    gap_mid    = gap_count[key_sel];
    clicks_mid = clicks_so_far[key_sel];
    quick      = 1'b0;

    sample_next   = sample;
    stable_next   = stable_flag[key_sel];
    debounce_next = debounce_count[key_sel];
    hold_next     = hold_count[key_sel];
    long_next     = long_started[key_sel];
    ignore_next   = ignore_click[key_sel];
    clicks_next   = clicks_so_far[key_sel];
    gap_next      = gap_count[key_sel];

    cand_valid = '0;
    for (int i = 0; i < 3; i++) begin
      cand[i].event_key   = in_data.key_index;
      cand[i].event_code  = EV_RELEASE;
      cand[i].click_count = 4'd0;
      cand[i].last_event  = 1'b0;
    end

    // debounce
    if (sample != previous_sample[key_sel]) begin
      debounce_next = 8'd0;
      stable_next   = 1'b0;
    end else if (debounce_count[key_sel] < debounce_ticks) begin
      debounce_next = db_inc;
      if (db_inc >= debounce_ticks) begin
        stable_next = 1'b1;
      end
    end

    if (stable_next) begin
      if (pressed) begin
        cand_valid[0]      = hold_count[key_sel] == '0;
        cand[0].event_code = EV_PRESS;
        if (hold_count[key_sel] < lpt) begin
          hold_next = hold_inc;
          if (hold_inc >= lpt) begin
            hold_next          = hold_inc - rep;
            cand_valid[1]      = 1'b1;
            cand[1].event_code = long_started[key_sel] ? EV_REPEAT : EV_LONG;
            long_next          = 1'b1;
            ignore_next        = clear_click_after_long;
          end
        end
      end else begin
        cand_valid[0]      = hold_count[key_sel] != '0;
        cand[0].event_code = EV_RELEASE;
        quick = !ignore_click[key_sel] && (hold_count[key_sel] != '0) &&
                (hold_count[key_sel] <= click_gap_ticks);
        if (quick) begin
          if (maxc == 4'd1) begin
            cand_valid[1]       = 1'b1;
            cand[1].event_code  = EV_CLICK;
            cand[1].click_count = 4'd1;
          end else begin
            if (clicks_mid < maxc) begin
              clicks_mid = clicks_mid + 4'd1;
            end
            gap_mid = click_gap_ticks;
          end
        end
        clicks_next = clicks_mid;
        gap_next    = gap_mid;
        // gap expiry reports the pending multi-click
        if (gap_mid != '0) begin
          gap_next = gap_mid - 16'd1;
          if (gap_mid == 16'd1) begin
            cand_valid[2]       = 1'b1;
            cand[2].event_code  = EV_CLICK;
            cand[2].click_count = clicks_mid;
            clicks_next         = 4'd0;
          end
        end
        long_next   = 1'b0;
        ignore_next = 1'b0;
        hold_next   = 16'd0;
      end
    end
  end

  // keep the first two events, mark the final one
  always_comb begin
    ev0 = cand[2];
    ev1 = cand[2];
    if (cand_valid[0]) begin
      ev0 = cand[0];
      ev1 = cand_valid[1] ? cand[1] : cand[2];
    end else if (cand_valid[1]) begin
      ev0 = cand[1];
    end
    case (cand_valid)
      3'b000:                   push_n = 2'd0;
      3'b001, 3'b010, 3'b100:   push_n = 2'd1;
      default:                  push_n = 2'd2;
    endcase
    if (!in_fire || !key_ok || in_data.req_type) begin
      push_n = 2'd0;
    end
    ev0.last_event = push_n == 2'd1;
    ev1.last_event = 1'b1;
  end

  // per-key state update
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (rst) begin
        previous_sample[i] <= SAMPLE_NONE;
        stable_flag[i]     <= 1'b0;
        debounce_count[i]  <= '0;
        hold_count[i]      <= '0;
        long_started[i]    <= 1'b0;
        ignore_click[i]    <= 1'b0;
        clicks_so_far[i]   <= '0;
        gap_count[i]       <= '0;
      end else if (in_fire && key_ok && key_sel == KEY_W'(i)) begin
        if (in_data.req_type) begin
          // key reset keeps only the click suppression
          previous_sample[i] <= SAMPLE_NONE;
          stable_flag[i]     <= 1'b0;
          debounce_count[i]  <= '0;
          hold_count[i]      <= '0;
          long_started[i]    <= 1'b0;
          clicks_so_far[i]   <= '0;
          gap_count[i]       <= '0;
        end else begin
          previous_sample[i] <= sample_next;
          stable_flag[i]     <= stable_next;
          debounce_count[i]  <= debounce_next;
          hold_count[i]      <= hold_next;
          long_started[i]    <= long_next;
          ignore_click[i]    <= ignore_next;
          clicks_so_far[i]   <= clicks_next;
          gap_count[i]       <= gap_next;
        end
      end
    end
  end

  // event queue payload
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= ev0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= ev1;
    end
  end

  // event queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_n) - QCNT_W'(out_fire);
    end
  end

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QDEPTH))
    else $error("event queue overflow");

  // key resets and out-of-range keys add no events
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && (!key_ok || in_data.req_type)) |=>
      (32'(count) == 32'($past(count)) - 32'($past(out_fire))))
    else $error("event queued for a request that makes none");

  // a released, settled key holds no hold count
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && key_ok && !in_data.req_type && stable_next &&
     (in_data.pin_level != active_high)) |-> (hold_next == 16'd0))
    else $error("hold count kept after release");

endmodule

// ===== tb/button_gesture_event_detector_top_tb.sv =====
// ----------------------------------------------------------------------------
// button_gesture_event_detector_top_tb
// self-checking bench: a shadow model of the key state predicts every
// gesture event and each out transfer is checked against the oldest one
// ----------------------------------------------------------------------------
module button_gesture_event_detector_top_tb
  import bged_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKEYS        = 4;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 60;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 6;    // margin after the last event

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  bged_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  bged_out_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  button_gesture_event_detector_top #(.NUM_KEYS(NKEYS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow settings, written when a cfg transfer completes
  // ---------------------------------------------------------------------------
  logic        set_active_high = DEF_ACTIVE_HIGH;
  logic [7:0]  set_debounce    = DEF_DEBOUNCE;
  logic [3:0]  set_max_clicks  = DEF_MAX_CLICKS;
  logic [15:0] set_click_gap   = DEF_CLICK_GAP;
  logic [15:0] set_long_press  = DEF_LONG_PRESS;
  logic [15:0] set_repeat      = DEF_REPEAT;
  logic        set_clear_click = DEF_CLEAR_CLICK;

  // shadow per-key state
  logic [1:0]  key_prev    [NKEYS];
  logic        key_pressed [NKEYS];
  logic        key_stable  [NKEYS];
  logic [7:0]  key_bounce  [NKEYS];
  logic [15:0] key_hold    [NKEYS];
  logic        key_long    [NKEYS];
  logic        key_noclick [NKEYS];
  logic [3:0]  key_clicks  [NKEYS];
  logic [15:0] key_gap     [NKEYS];

  bged_in_t  pending_samples[$];  // items waiting for the driver
  bged_out_t due_events[$];       // predicted events, oldest first

  logic in_taken = 1'b0;          // input transfer at the last rising edge
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 14;
  int   recv_idle_pct = 83;
  int   hold_req = 0;             // bumped by the sequencer to ask for a hold-off
  int   hold_seen = 0;
  int   hold_left = 0;

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_ACTIVE_HIGH: set_active_high = val[0];
      CFG_DEBOUNCE:    set_debounce    = val[7:0];
      CFG_MAX_CLICKS:  set_max_clicks  = val[3:0];
      CFG_CLICK_GAP:   set_click_gap   = val;
      CFG_LONG_PRESS:  set_long_press  = val;
      CFG_REPEAT:      set_repeat      = val;
      CFG_CLEAR_CLICK: set_clear_click = val[0];
      default: ;
    endcase
  endfunction

  // key_pressed and key_noclick survive a per-key reset
  function automatic void clear_key(int k);
    key_prev[k]   = SAMPLE_NONE;
    key_stable[k] = 1'b0;
    key_long[k]   = 1'b0;
    key_bounce[k] = '0;
    key_clicks[k] = '0;
    key_gap[k]    = '0;
    key_hold[k]   = '0;
  endfunction

  function automatic bged_out_t gesture_event(int k, logic [2:0] code, logic [3:0] cnt);
    bged_out_t ev;
    ev.event_key   = 2'(k);
    ev.event_code  = code;
    ev.click_count = cnt;
    ev.last_event  = 1'b0;
    return ev;
  endfunction

  // one tick of one key: updates the shadow state and queues its events
  function automatic void predict_gesture(bged_in_t item);
    int          k;
    int          i;
    logic [1:0]  smp;
    logic [15:0] lpt;
    logic [15:0] rep;
    logic [3:0]  maxc;
    bged_out_t   ev;
    bged_out_t   evs[$];
    k = item.key_index;
    if (item.req_type) begin
      clear_key(k);
      return;
    end
    smp = {1'b0, item.pin_level} + 2'd1;
    key_pressed[k] = (item.pin_level == set_active_high);
    // debounce: level settles after enough equal samples in a row
    if (smp != key_prev[k]) begin
      key_bounce[k] = '0;
      key_stable[k] = 1'b0;
    end else if (key_bounce[k] < set_debounce) begin
      key_bounce[k] = key_bounce[k] + 8'd1;
      if (key_bounce[k] >= set_debounce) key_stable[k] = 1'b1;
    end
    key_prev[k] = smp;
    if (!key_stable[k]) return;

    lpt  = (set_long_press != 0) ? set_long_press : 16'd1;
    rep  = (set_repeat < lpt) ? set_repeat : 16'd0;
    maxc = (set_max_clicks != 0) ? set_max_clicks : 4'd1;

    if (key_pressed[k]) begin
      if (key_hold[k] == 0) evs.push_back(gesture_event(k, EV_PRESS, 4'd0));
      if (key_hold[k] < lpt) begin
        key_hold[k] = key_hold[k] + 16'd1;
        if (key_hold[k] >= lpt) begin
          key_hold[k] = key_hold[k] - rep;
          evs.push_back(gesture_event(k, key_long[k] ? EV_REPEAT : EV_LONG, 4'd0));
          key_long[k]    = 1'b1;
          key_noclick[k] = set_clear_click;
        end
      end
    end else begin
      if (key_hold[k] != 0) evs.push_back(gesture_event(k, EV_RELEASE, 4'd0));
      if (!key_noclick[k] && key_hold[k] != 0 && key_hold[k] <= set_click_gap) begin
        if (maxc == 4'd1) begin
          evs.push_back(gesture_event(k, EV_CLICK, 4'd1));
        end else begin
          if (key_clicks[k] < maxc) key_clicks[k] = key_clicks[k] + 4'd1;
          key_gap[k] = set_click_gap;
        end
      end
      if (key_gap[k] != 0) begin
        key_gap[k] = key_gap[k] - 16'd1;
        if (key_gap[k] == 0) begin
          evs.push_back(gesture_event(k, EV_CLICK, key_clicks[k]));
          key_clicks[k] = '0;
        end
      end
      key_long[k]    = 1'b0;
      key_noclick[k] = 1'b0;
      key_hold[k]    = '0;
    end

    // only the first two events of a tick reach the output
    for (i = 0; i < evs.size() && i < 2; i++) begin
      ev = evs[i];
      ev.last_event = (i == evs.size() - 1) || (i == 1);
      due_events.push_back(ev);
    end
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: all sampling happens at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor_proc
    bged_out_t want;
    if (rst) begin
      in_taken <= 1'b0;
      for (int k = 0; k < NKEYS; k++) begin
        clear_key(k);
        key_pressed[k] = 1'b0;
        key_noclick[k] = 1'b0;
      end
    end else begin
      in_taken <= in_valid && !in_stall;
      // input transfer: predict before looking at the output side
      if (in_valid && !in_stall) predict_gesture(in_data);
      // output transfer: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_events.size() == 0) begin
          $display("%0t: unexpected event, actual key=%0d code=%0d count=%0d last=%0d",
                   $time, out_data.event_key, out_data.event_code,
                   out_data.click_count, out_data.last_event);
          mismatch_count++;
        end else begin
          want = due_events.pop_front();
          check_field("event_key",   want.event_key,   out_data.event_key);
          check_field("event_code",  want.event_code,  out_data.event_code);
          check_field("click_count", want.click_count, out_data.click_count);
          check_field("last_event",  want.last_event,  out_data.last_event);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: inputs change at the falling edge only
  // ---------------------------------------------------------------------------
  // a new item is offered only once the previous one made its transfer,
  // so valid never looks at stall and a stalled payload holds
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, plus a long hold-off when the sequencer asks
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // writes every register; unused upper data bits carry junk
  task automatic configure(logic ah, logic [7:0] deb, logic [3:0] mc,
                           logic [15:0] gap, logic [15:0] lp, logic [15:0] rep,
                           logic clr);
    write_reg(CFG_ACTIVE_HIGH, {15'($urandom), ah});
    write_reg(CFG_DEBOUNCE,    {8'($urandom), deb});
    write_reg(CFG_MAX_CLICKS,  {12'($urandom), mc});
    write_reg(CFG_CLICK_GAP,   gap);
    write_reg(CFG_LONG_PRESS,  lp);
    write_reg(CFG_REPEAT,      rep);
    write_reg(CFG_CLEAR_CLICK, {15'($urandom), clr});
  endtask

  task automatic push_run(int k, logic level, int count);
    bged_in_t item;
    item = {1'b0, 2'(k), level};
    repeat (count) pending_samples.push_back(item);
  endtask

  task automatic push_key_reset(int k, logic pin);
    bged_in_t item;
    item = {1'b1, 2'(k), pin};
    pending_samples.push_back(item);
  endtask

  // mostly held levels per key with random run lengths, some glitches and
  // key resets mixed in
  task automatic gen_random(int n, int short_max, int long_max);
    logic     lvl  [NKEYS];
    int       left [NKEYS];
    int       k;
    int       roll;
    bged_in_t item;
    for (k = 0; k < NKEYS; k++) begin
      lvl[k]  = 1'($urandom);
      left[k] = 0;
    end
    repeat (n) begin
      roll = $urandom_range(0, 99);
      k    = $urandom_range(0, NKEYS - 1);
      if (roll < 3) begin
        push_key_reset(k, 1'($urandom));
      end else if (roll < 7) begin
        item = {1'b0, 2'(k), 1'($urandom)};
        pending_samples.push_back(item);
      end else begin
        if (left[k] == 0) begin
          lvl[k]  = ($urandom_range(0, 9) < 8) ? ~lvl[k] : 1'($urandom);
          left[k] = ($urandom_range(0, 9) < 7) ? $urandom_range(1, short_max)
                                                : $urandom_range(1, long_max);
        end
        item = {1'b0, 2'(k), lvl[k]};
        pending_samples.push_back(item);
        left[k]--;
      end
    end
  endtask

  // wait until every item has made its transfer and every event has arrived
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_samples.size() != 0 || in_valid || due_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: one-tick debounce, multi-click up to 4, short long press
    configure(1'b1, 8'd1, 4'd4, 16'd3, 16'd4, 16'd2, 1'b1);
    push_run(0, 1'b0, 2);   // settles released, no event
    push_run(0, 1'b1, 2);   // press
    push_run(0, 1'b0, 3);   // release, click counted, gap runs down
    push_run(0, 1'b1, 2);   // press with a multi-click still pending
    settle();
    // drop to single clicks while the multi-click is pending: the next
    // release owes three events and only two come out
    write_reg(CFG_MAX_CLICKS, {12'($urandom), 4'd1});
    push_run(0, 1'b0, 2);
    push_run(1, 1'b1, 7);   // press, long start, one repeat
    push_run(1, 1'b0, 2);   // release after long press, click suppressed
    push_run(2, 1'b1, 2);   // press
    push_key_reset(2, 1'b1);
    push_run(2, 1'b1, 2);   // state cleared, so a fresh press
    settle();

    // random phases, first with a slow receiver
    configure(1'b1, 8'd1, 4'd1, 16'd6, 16'd10, 16'd3, 1'b1);
    gen_random(250, 9, 25);
    settle();

    configure(1'b0, 8'd3, 4'd3, 16'd8, 16'd12, 16'd0, 1'b0);
    gen_random(250, 14, 20);
    settle();

    // one-tick long press: each press brings two events; the receiver holds
    // off meanwhile so the event queue fills and in_stall rises
    configure(1'b1, 8'd2, 4'd15, 16'd5, 16'd1, 16'd0, 1'b1);
    hold_req = hold_req + 1;
    gen_random(250, 8, 12);
    settle();

    // slow sender from here
    send_idle_pct = 83;
    recv_idle_pct = 14;
    // zero debounce never settles a new level
    configure(1'b0, 8'd0, 4'd2, 16'd4, 16'd6, 16'd1, 1'b0);
    gen_random(150, 6, 15);
    settle();

    // zero max clicks, zero click gap, zero long press, repeat out of range
    configure(1'b1, 8'd1, 4'd0, 16'd0, 16'd0, 16'hffff, 1'b0);
    gen_random(250, 5, 10);
    settle();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1'b0, 8'd2, 4'd2, 16'd1, 16'd6, 16'd1, 1'b1);
    gen_random(250, 5, 15);
    settle();

    // largest settings on one key
    configure(1'b1, 8'd255, 4'd15, 16'hffff, 16'hffff, 16'hfffe, 1'b0);
    push_run(2, 1'b0, 260);
    push_run(2, 1'b1, 260);
    push_run(2, 1'b0, 260);
    settle();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
